// File: hdl/clipped_primitive_rasterizer_defines.svh
// assertion macros for the clipped primitive rasterizer
// used by the top level only; bodies are empty when SYNTHESIS is defined
`ifndef CLIPPED_PRIMITIVE_RASTERIZER_DEFINES_SVH
`define CLIPPED_PRIMITIVE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpr assertion failed");
// next-cycle implication
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpr assertion failed");
`else
`define CPR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/cpr_pkg.sv
// shared types, command codes and defaults of the clipped primitive rasterizer
// no dependencies; used by cpr_engine, cpr_emit, the top level and the testbench
package cpr_pkg;

    // default screen size
    localparam int CPR_SCREEN_W = 320;
    localparam int CPR_SCREEN_H = 200;

    // command codes carried on the input selector
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_PIXEL  = 3'd1;
    localparam logic [2:0] FN_HLINE  = 3'd2;
    localparam logic [2:0] FN_VLINE  = 3'd3;
    localparam logic [2:0] FN_RECT   = 3'd4;
    localparam logic [2:0] FN_CIRCLE = 3'd5;
    localparam logic [2:0] FN_DISC   = 3'd6;

    // last octant of one circle step
    localparam logic [2:0] OCT_LAST = 3'd7;

    // primitive in progress
    typedef enum logic [2:0] {
        OP_IDLE   = 3'd0,
        OP_PIXEL  = 3'd1,
        OP_BOX    = 3'd4,
        OP_CIRCLE = 3'd5,
        OP_DISC   = 3'd6
    } t_op;

    // candidate pixel handed from the engine to the emit stage
    typedef struct packed {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic               in_shape;
        logic [7:0]         color;
        logic               more;
    } t_cand;

    // engine status seen by the top level
    typedef struct packed {
        logic busy;
        logic fire;
        logic more;
    } t_stat;

endpackage

// File: hdl/cpr_engine.sv
// drawing engine: command load, scan / circle / disc stepping, candidate register
// depends on cpr_pkg
module cpr_engine #(
    parameter int SCREEN_W = cpr_pkg::CPR_SCREEN_W,
    parameter int SCREEN_H = cpr_pkg::CPR_SCREEN_H
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_func,
    input  logic signed [15:0] i_x_a,
    input  logic signed [15:0] i_y_a,
    input  logic signed [15:0] i_x_b,
    input  logic signed [15:0] i_y_b,
    input  logic [7:0]         i_radius,
    input  logic [7:0]         i_color,
    output logic               o_cand_valid,
    input  logic               i_cand_ready,
    output cpr_pkg::t_cand     o_cand,
    output cpr_pkg::t_stat     o_stat
);
    import cpr_pkg::*;

    localparam logic signed [15:0] X_MAX = 16'(SCREEN_W - 1);
    localparam logic signed [15:0] Y_MAX = 16'(SCREEN_H - 1);

    // state
    t_op                r_op, n_op;
    logic signed [15:0] r_scan_x, n_scan_x, r_scan_y, n_scan_y;
    logic signed [15:0] r_row_start, n_row_start, r_end_x, n_end_x, r_end_y, n_end_y;
    logic signed [15:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [9:0]  r_u, n_u, r_v, n_v;
    logic signed [11:0] r_err, n_err;
    logic [2:0]         r_oct, n_oct;
    logic [7:0]         r_radius, n_radius;
    logic [15:0]        r_r2, n_r2;
    logic [7:0]         r_color, n_color;
    logic               r_cand_valid;
    t_cand              r_cand;
    t_cand              cand;

    logic accept, is_cmd, fire;

    // handshake
    assign o_ready = !r_cand_valid || i_cand_ready;
    assign accept  = i_valid && o_ready;
    assign is_cmd  = (i_func != FN_TICK) && (i_func <= FN_DISC) && (r_op == OP_IDLE);
    assign fire    = accept && (i_func == FN_TICK) && (r_op != OP_IDLE);

    // box operands: order, clamp, emptiness
    logic signed [15:0] b_x2, b_y2, b_lx, b_hx, b_ly, b_hy;
    logic signed [15:0] b_cx1, b_cx2, b_cy1, b_cy2;
    logic               b_ok;
    always_comb begin
        b_x2  = (i_func == FN_VLINE) ? i_x_a : i_x_b;
        b_y2  = (i_func == FN_HLINE) ? i_y_a : i_y_b;
        b_lx  = (i_x_a > b_x2) ? b_x2 : i_x_a;
        b_hx  = (i_x_a > b_x2) ? i_x_a : b_x2;
        b_ly  = (i_y_a > b_y2) ? b_y2 : i_y_a;
        b_hy  = (i_y_a > b_y2) ? i_y_a : b_y2;
        b_cx1 = (b_lx < 16'sd0) ? 16'sd0 : b_lx;
        b_cy1 = (b_ly < 16'sd0) ? 16'sd0 : b_ly;
        b_cx2 = (b_hx > X_MAX) ? X_MAX : b_hx;
        b_cy2 = (b_hy > Y_MAX) ? Y_MAX : b_hy;
        b_ok  = (b_cx1 <= b_cx2) && (b_cy1 <= b_cy2);
        if (i_func == FN_HLINE) begin
            b_ok = b_ok && (i_y_a >= 16'sd0) && (i_y_a <= Y_MAX);
        end
        if (i_func == FN_VLINE) begin
            b_ok = b_ok && (i_x_a >= 16'sd0) && (i_x_a <= X_MAX);
        end
    end

    // midpoint circle step taken after the last octant
    logic signed [9:0]  c_v1, c_u1, c_diff, c_unew;
    logic signed [11:0] c_inc_a, c_inc_b, c_err;
    logic               c_done;
    always_comb begin
        c_v1    = r_v + 10'sd1;
        c_u1    = r_u - 10'sd1;
        c_diff  = c_v1 - c_u1;
        c_inc_a = {c_v1[9], c_v1, 1'b1};
        c_inc_b = {c_diff[9], c_diff, 1'b1};
        c_err   = r_err + (r_err[11] ? c_inc_a : c_inc_b);
        c_unew  = r_err[11] ? r_u : c_u1;
        c_done  = c_unew < c_v1;
    end

    // scan end tests for box and disc
    logic signed [9:0]  d_r;
    logic signed [19:0] d_uu, d_vv;
    logic [20:0]        d_sum;
    logic               d_u_end, d_v_end, b_x_end, b_y_end;
    always_comb begin
        d_r     = {2'b00, r_radius};
        d_u_end = r_u >= d_r;
        d_v_end = r_v >= d_r;
        d_uu    = r_u * r_u;
        d_vv    = r_v * r_v;
        d_sum   = {1'b0, d_uu} + {1'b0, d_vv};
        b_x_end = r_scan_x >= r_end_x;
        b_y_end = r_scan_y >= r_end_y;
    end

    // next state
    always_comb begin
        n_op        = r_op;
        n_scan_x    = r_scan_x;
        n_scan_y    = r_scan_y;
        n_row_start = r_row_start;
        n_end_x     = r_end_x;
        n_end_y     = r_end_y;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_u         = r_u;
        n_v         = r_v;
        n_err       = r_err;
        n_oct       = r_oct;
        n_radius    = r_radius;
        n_r2        = r_r2;
        n_color     = r_color;
        if (accept && is_cmd) begin
            n_color  = i_color;
            n_radius = i_radius;
            n_r2     = i_radius * i_radius;
            unique case (i_func)
                FN_PIXEL: begin
                    n_scan_x = i_x_a;
                    n_scan_y = i_y_a;
                    n_op     = OP_PIXEL;
                end
                FN_HLINE, FN_VLINE, FN_RECT: begin
                    if (b_ok) begin
                        n_row_start = b_cx1;
                        n_scan_x    = b_cx1;
                        n_scan_y    = b_cy1;
                        n_end_x     = b_cx2;
                        n_end_y     = b_cy2;
                        n_op        = OP_BOX;
                    end
                end
                FN_CIRCLE: begin
                    n_cx  = i_x_a;
                    n_cy  = i_y_a;
                    n_u   = {2'b00, i_radius};
                    n_v   = 10'sd0;
                    n_err = 12'sd1 - {4'b0000, i_radius};
                    n_oct = 3'd0;
                    n_op  = OP_CIRCLE;
                end
                default: begin
                    n_cx = i_x_a;
                    n_cy = i_y_a;
                    n_u  = 10'sd0 - {2'b00, i_radius};
                    n_v  = 10'sd0 - {2'b00, i_radius};
                    n_op = OP_DISC;
                end
            endcase
        end else if (fire) begin
            unique case (r_op)
                OP_PIXEL: n_op = OP_IDLE;
                OP_BOX: begin
                    if (!b_x_end) begin
                        n_scan_x = r_scan_x + 16'sd1;
                    end else if (!b_y_end) begin
                        n_scan_y = r_scan_y + 16'sd1;
                        n_scan_x = r_row_start;
                    end else begin
                        n_op = OP_IDLE;
                    end
                end
                OP_CIRCLE: begin
                    if (r_oct != OCT_LAST) begin
                        n_oct = r_oct + 3'd1;
                    end else begin
                        n_oct = 3'd0;
                        n_v   = c_v1;
                        n_u   = c_unew;
                        n_err = c_err;
                        if (c_done) begin
                            n_op = OP_IDLE;
                        end
                    end
                end
                OP_DISC: begin
                    if (!d_u_end) begin
                        n_u = r_u + 10'sd1;
                    end else if (!d_v_end) begin
                        n_v = r_v + 10'sd1;
                        n_u = -d_r;
                    end else begin
                        n_op = OP_IDLE;
                    end
                end
                default: n_op = r_op;
            endcase
        end
    end

    // candidate of the current step
    logic signed [16:0] s_cx, s_cy, s_u, s_v;
    always_comb begin
        s_cx          = {r_cx[15], r_cx};
        s_cy          = {r_cy[15], r_cy};
        s_u           = {{7{r_u[9]}}, r_u};
        s_v           = {{7{r_v[9]}}, r_v};
        cand.px       = {r_scan_x[15], r_scan_x};
        cand.py       = {r_scan_y[15], r_scan_y};
        cand.in_shape = 1'b1;
        cand.color    = r_color;
        cand.more     = 1'b0;
        unique case (r_op)
            OP_PIXEL: cand.more = 1'b0;
            OP_BOX:   cand.more = !(b_x_end && b_y_end);
            OP_CIRCLE: begin
                cand.more = (r_oct != OCT_LAST) || !c_done;
                unique case (r_oct)
                    3'd0: begin cand.px = s_cx + s_u; cand.py = s_cy + s_v; end
                    3'd1: begin cand.px = s_cx + s_v; cand.py = s_cy + s_u; end
                    3'd2: begin cand.px = s_cx - s_v; cand.py = s_cy + s_u; end
                    3'd3: begin cand.px = s_cx - s_u; cand.py = s_cy + s_v; end
                    3'd4: begin cand.px = s_cx - s_u; cand.py = s_cy - s_v; end
                    3'd5: begin cand.px = s_cx - s_v; cand.py = s_cy - s_u; end
                    3'd6: begin cand.px = s_cx + s_v; cand.py = s_cy - s_u; end
                    default: begin cand.px = s_cx + s_u; cand.py = s_cy - s_v; end
                endcase
            end
            OP_DISC: begin
                cand.px       = s_cx + s_u;
                cand.py       = s_cy + s_v;
                cand.in_shape = d_sum <= {5'b00000, r_r2};
                cand.more     = !(d_u_end && d_v_end);
            end
            default: cand.more = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= OP_IDLE;
            r_cand_valid <= 1'b0;
        end else begin
            r_op <= n_op;
            if (fire) begin
                r_cand_valid <= 1'b1;
            end else if (i_cand_ready) begin
                r_cand_valid <= 1'b0;
            end
        end
    end

    // operand and candidate registers
    always_ff @(posedge i_clk) begin
        r_scan_x    <= n_scan_x;
        r_scan_y    <= n_scan_y;
        r_row_start <= n_row_start;
        r_end_x     <= n_end_x;
        r_end_y     <= n_end_y;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_u         <= n_u;
        r_v         <= n_v;
        r_err       <= n_err;
        r_oct       <= n_oct;
        r_radius    <= n_radius;
        r_r2        <= n_r2;
        r_color     <= n_color;
        if (fire) begin
            r_cand <= cand;
        end
    end

    assign o_cand_valid = r_cand_valid;
    assign o_cand       = r_cand;
    assign o_stat.busy  = r_op != OP_IDLE;
    assign o_stat.fire  = fire;
    assign o_stat.more  = cand.more;

endmodule

// File: hdl/cpr_emit.sv
// emit stage: screen clip, frame buffer address and output register
// depends on cpr_pkg
module cpr_emit #(
    parameter int SCREEN_W = cpr_pkg::CPR_SCREEN_W,
    parameter int SCREEN_H = cpr_pkg::CPR_SCREEN_H
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cand_valid,
    output logic           o_cand_ready,
    input  cpr_pkg::t_cand i_cand,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_write_enable,
    output logic [8:0]     o_pixel_x,
    output logic [7:0]     o_pixel_y,
    output logic [15:0]    o_pixel_addr,
    output logic [7:0]     o_pixel_color,
    output logic           o_more
);
    import cpr_pkg::*;

    localparam logic signed [16:0] W_S = 17'(SCREEN_W);
    localparam logic signed [16:0] H_S = 17'(SCREEN_H);
    localparam logic [15:0]        W_U = 16'(SCREEN_W);

    logic        r_valid;
    logic        r_we, r_more;
    logic [8:0]  r_x;
    logic [7:0]  r_y, r_color;
    logic [15:0] r_addr;
    logic        on;
    logic [15:0] addr;

    assign o_cand_ready = !r_valid || i_ready;

    // clip against the screen and form row * width + column
    always_comb begin
        on   = i_cand.in_shape && !i_cand.px[16] && (i_cand.px < W_S)
               && !i_cand.py[16] && (i_cand.py < H_S);
        addr = i_cand.py[15:0] * W_U + i_cand.px[15:0];
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cand_ready) begin
            r_valid <= i_cand_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cand_valid && o_cand_ready) begin
            r_we    <= on;
            r_x     <= on ? i_cand.px[8:0] : 9'd0;
            r_y     <= on ? i_cand.py[7:0] : 8'd0;
            r_addr  <= on ? addr : 16'd0;
            r_color <= i_cand.color;
            r_more  <= i_cand.more;
        end
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_we;
    assign o_pixel_x      = r_x;
    assign o_pixel_y      = r_y;
    assign o_pixel_addr   = r_addr;
    assign o_pixel_color  = r_color;
    assign o_more         = r_more;

endmodule

// File: hdl/clipped_primitive_rasterizer.sv
// top level of the clipped primitive rasterizer: stream ports and assertions
// depends on cpr_pkg, cpr_engine, cpr_emit and clipped_primitive_rasterizer_defines.svh
//
// channel   direction  payload
// s_axis    in         tuser: func; tdata: x_a, y_a, x_b, y_b, radius, color
// m_axis    out        tuser: write_enable; tdata: pixel_x .. pixel_color;
//                      tlast: no further candidate of this primitive
//
// one item accepted per cycle while s_axis_tready is high; a tick's candidate passes
// the engine candidate register, then the clip/address output register
// s_axis_tready falls only when both registers hold a candidate and m_axis_tready is low
// synchronous active-low reset empties both registers and leaves the engine idle
`include "clipped_primitive_rasterizer_defines.svh"

module clipped_primitive_rasterizer #(
    parameter int SCREEN_W = cpr_pkg::CPR_SCREEN_W,
    parameter int SCREEN_H = cpr_pkg::CPR_SCREEN_H
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] x_a, [31:16] y_a, [47:32] x_b, [63:48] y_b, [71:64] radius, [79:72] color
    input  logic [79:0] s_axis_tdata,
    // [2:0] func
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [8:0] pixel_x, [16:9] pixel_y, [32:17] pixel_addr, [40:33] pixel_color, [47:41] zero
    output logic [47:0] m_axis_tdata,
    // [0] write_enable
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import cpr_pkg::*;

    logic        cand_valid, cand_ready;
    t_cand       cand;
    t_stat       stat;
    logic        we, more;
    logic [8:0]  px;
    logic [7:0]  py, color;
    logic [15:0] addr;

    // command and scan engine
    cpr_engine #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser),
        .i_x_a        (s_axis_tdata[15:0]),
        .i_y_a        (s_axis_tdata[31:16]),
        .i_x_b        (s_axis_tdata[47:32]),
        .i_y_b        (s_axis_tdata[63:48]),
        .i_radius     (s_axis_tdata[71:64]),
        .i_color      (s_axis_tdata[79:72]),
        .o_cand_valid (cand_valid),
        .i_cand_ready (cand_ready),
        .o_cand       (cand),
        .o_stat       (stat)
    );

    // clip and address stage
    cpr_emit #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cand_valid   (cand_valid),
        .o_cand_ready   (cand_ready),
        .i_cand         (cand),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_write_enable (we),
        .o_pixel_x      (px),
        .o_pixel_y      (py),
        .o_pixel_addr   (addr),
        .o_pixel_color  (color),
        .o_more         (more)
    );

    // result packing
    assign m_axis_tdata = {7'd0, color, addr, py, px};
    assign m_axis_tuser = we;
    assign m_axis_tlast = !more;

    // a skipped pixel carries no coordinates
    `CPR_ASSERT_SAME(a_off_screen_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[32:0] == 33'd0)
    // the last candidate of a primitive leaves the engine idle
    `CPR_ASSERT_NEXT(a_last_goes_idle, i_clk, i_rst_n,
        stat.fire && !stat.more, !stat.busy)
    // a candidate with more to come keeps the engine busy
    `CPR_ASSERT_NEXT(a_more_stays_busy, i_clk, i_rst_n,
        stat.fire && stat.more, stat.busy)
    // an empty output register never stalls the input
    `CPR_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n,
        !m_axis_tvalid, s_axis_tready)

endmodule

// File: tb/clipped_primitive_rasterizer_test.sv
// self-checking testbench for the clipped primitive rasterizer
// directed primitives, then random command and tick streams under several idle and stall mixes
// depends on cpr_pkg and clipped_primitive_rasterizer
`timescale 1ns / 1ps

module clipped_primitive_rasterizer_test;

    import cpr_pkg::*;

    // selector value that the block ignores
    localparam logic [2:0] FN_UNUSED = 3'd7;

    // one input transaction, fields as carried on s_axis
    typedef struct {
        logic [2:0]         func;
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
        logic [7:0]         radius;
        logic [7:0]         color;
    } t_cmd;

    // one candidate pixel, field order matches the packing in the receiver
    typedef struct packed {
        logic        we;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [15:0] addr;
        logic [7:0]  color;
        logic        last;
    } t_pixel;

    // predicts candidate pixels and checks them in order
    class pixel_scoreboard;
        t_op        op;
        int         scan_col, scan_row, first_col, last_col, last_row;
        int         cen_x, cen_y, arc_x, arc_y, arc_d;
        bit [2:0]   oct_idx;
        bit [7:0]   held_radius, held_color;
        t_pixel     pixel_q[$];
        int         failures;

        function new();
            op = OP_IDLE;
            scan_col = 0; scan_row = 0; first_col = 0; last_col = 0; last_row = 0;
            cen_x = 0; cen_y = 0; arc_x = 0; arc_y = 0; arc_d = 0;
            oct_idx = 0; held_radius = 0; held_color = 0;
            failures = 0;
        endfunction

        function bit busy();
            return op != OP_IDLE;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        // candidate with on-screen test and address
        function t_pixel make_pixel(int x, int y, bit more_flag);
            t_pixel p;
            bit     on;
            on = x >= 0 && x < CPR_SCREEN_W && y >= 0 && y < CPR_SCREEN_H;
            p.we = on;
            p.x = on ? 9'(x) : '0;
            p.y = on ? 8'(y) : '0;
            p.addr = on ? 16'(y * CPR_SCREEN_W + x) : '0;
            p.color = held_color;
            p.last = !more_flag;
            return p;
        endfunction

        // order, clamp and load a box scan; an empty box leaves the engine idle
        function void load_box(int x1, int y1, int x2, int y2);
            int t;
            if (x1 > x2) begin
                t = x1; x1 = x2; x2 = t;
            end
            if (y1 > y2) begin
                t = y1; y1 = y2; y2 = t;
            end
            if (x1 < 0) x1 = 0;
            if (y1 < 0) y1 = 0;
            if (x2 > CPR_SCREEN_W - 1) x2 = CPR_SCREEN_W - 1;
            if (y2 > CPR_SCREEN_H - 1) y2 = CPR_SCREEN_H - 1;
            if (x1 > x2 || y1 > y2) return;
            first_col = x1; scan_col = x1; scan_row = y1; last_col = x2; last_row = y2;
            op = OP_BOX;
        endfunction

        // notes one accepted transaction; returns 1 if the block acts on it
        function bit note_input(t_cmd c);
            int     r, u, v, px, py;
            bit     more_flag, in_disc;
            t_pixel p;
            if (c.func == FN_UNUSED) return 0;
            // commands load only while idle
            if (c.func != FN_TICK) begin
                if (op != OP_IDLE) return 0;
                held_color = c.color;
                held_radius = c.radius;
                r = held_radius;
                case (c.func)
                    FN_PIXEL: begin
                        scan_col = c.xa; scan_row = c.ya; op = OP_PIXEL;
                    end
                    FN_HLINE: begin
                        if (c.ya >= 0 && c.ya < CPR_SCREEN_H)
                            load_box(c.xa, c.ya, c.xb, c.ya);
                    end
                    FN_VLINE: begin
                        if (c.xa >= 0 && c.xa < CPR_SCREEN_W)
                            load_box(c.xa, c.ya, c.xa, c.yb);
                    end
                    FN_RECT:  load_box(c.xa, c.ya, c.xb, c.yb);
                    FN_CIRCLE: begin
                        cen_x = c.xa; cen_y = c.ya;
                        arc_x = r; arc_y = 0; arc_d = 1 - r; oct_idx = 0;
                        op = OP_CIRCLE;
                    end
                    default: begin
                        cen_x = c.xa; cen_y = c.ya;
                        arc_x = -r; arc_y = -r;
                        op = OP_DISC;
                    end
                endcase
                return 1;
            end
            // tick
            if (op == OP_IDLE) return 0;
            r = held_radius;
            more_flag = 1'b1;
            case (op)
                OP_PIXEL: begin
                    op = OP_IDLE;
                    p = make_pixel(scan_col, scan_row, 1'b0);
                end
                OP_BOX: begin
                    px = scan_col; py = scan_row;
                    if (scan_col < last_col) begin
                        scan_col++;
                    end else if (scan_row < last_row) begin
                        scan_row++; scan_col = first_col;
                    end else begin
                        more_flag = 1'b0; op = OP_IDLE;
                    end
                    p = make_pixel(px, py, more_flag);
                end
                OP_CIRCLE: begin
                    u = arc_x; v = arc_y;
                    case (oct_idx)
                        3'd0: begin px = cen_x + u; py = cen_y + v; end
                        3'd1: begin px = cen_x + v; py = cen_y + u; end
                        3'd2: begin px = cen_x - v; py = cen_y + u; end
                        3'd3: begin px = cen_x - u; py = cen_y + v; end
                        3'd4: begin px = cen_x - u; py = cen_y - v; end
                        3'd5: begin px = cen_x - v; py = cen_y - u; end
                        3'd6: begin px = cen_x + v; py = cen_y - u; end
                        default: begin px = cen_x + u; py = cen_y - v; end
                    endcase
                    // midpoint step after the eighth octant point
                    if (oct_idx != OCT_LAST) begin
                        oct_idx++;
                    end else begin
                        oct_idx = 0;
                        arc_y++;
                        if (arc_d < 0) begin
                            arc_d += 2 * arc_y + 1;
                        end else begin
                            arc_x--;
                            arc_d += 2 * (arc_y - arc_x) + 1;
                        end
                        if (arc_x < arc_y) begin
                            more_flag = 1'b0; op = OP_IDLE;
                        end
                    end
                    p = make_pixel(px, py, more_flag);
                end
                default: begin
                    // disc: bounding box scan, write only inside the radius
                    u = arc_x; v = arc_y;
                    in_disc = u * u + v * v <= r * r;
                    if (arc_x < r) begin
                        arc_x++;
                    end else if (arc_y < r) begin
                        arc_y++; arc_x = -r;
                    end else begin
                        more_flag = 1'b0; op = OP_IDLE;
                    end
                    p = make_pixel(cen_x + u, cen_y + v, more_flag);
                    if (!in_disc) begin
                        p.we = 1'b0; p.x = '0; p.y = '0; p.addr = '0;
                    end
                end
            endcase
            pixel_q.push_back(p);
            return 1;
        endfunction

        // compares one output transaction with the oldest prediction
        function void check_result(t_pixel got);
            t_pixel want;
            if (pixel_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel: we=%0b x=%0d y=%0d addr=%0d color=%0d last=%0b",
                             got.we, got.x, got.y, got.addr, got.color, got.last);
                return;
            end
            want = pixel_q.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display({"pixel mismatch: expected ",
                              "we=%0b x=%0d y=%0d addr=%0d color=%0d last=%0b"},
                             want.we, want.x, want.y, want.addr, want.color, want.last);
                    $display({"                got      ",
                              "we=%0b x=%0d y=%0d addr=%0d color=%0d last=%0b"},
                             got.we, got.x, got.y, got.addr, got.color, got.last);
                end
            end
        endfunction

        // predictions that never came out
        function void check_drained();
            if (pixel_q.size() != 0) begin
                failures += pixel_q.size();
                $display("%0d predicted pixels never arrived", pixel_q.size());
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] x_a, [31:16] y_a, [47:32] x_b, [63:48] y_b, [71:64] radius, [79:72] color
    logic [79:0] s_axis_tdata = '0;
    // [2:0] func
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [8:0] pixel_x, [16:9] pixel_y, [32:17] pixel_addr, [40:33] pixel_color, [47:41] zero
    logic [47:0] m_axis_tdata;
    // [0] write_enable
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    pixel_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  counted_items = 0;
    logic rx_hold = 1'b0;

    clipped_primitive_rasterizer #(
        .SCREEN_W(CPR_SCREEN_W),
        .SCREEN_H(CPR_SCREEN_H)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // output side: check each transaction, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser[0], m_axis_tdata[8:0], m_axis_tdata[16:9],
                             m_axis_tdata[32:17], m_axis_tdata[40:33], m_axis_tlast});
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic t_cmd make_cmd(logic [2:0] func, int xa, int ya, int xb, int yb,
                                      int radius, int color);
        t_cmd c;
        c.func = func;
        c.xa = 16'(xa); c.ya = 16'(ya); c.xb = 16'(xb); c.yb = 16'(yb);
        c.radius = 8'(radius); c.color = 8'(color);
        return c;
    endfunction

    // coordinate mostly near the screen, sometimes anywhere
    function automatic logic signed [15:0] rand_coord(int span);
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(span + 19)) - 10);
    endfunction

    // random primitive with small sizes, unused fields filled with junk
    function automatic t_cmd random_primitive();
        t_cmd c;
        c.xa = rand_coord(CPR_SCREEN_W);
        c.ya = rand_coord(CPR_SCREEN_H);
        c.xb = 16'($urandom);
        c.yb = 16'($urandom);
        c.radius = 8'($urandom);
        c.color = 8'($urandom);
        case ($urandom_range(5))
            0: c.func = FN_PIXEL;
            1: begin
                c.func = FN_HLINE;
                if ($urandom_range(3) != 0)
                    c.xb = 16'(int'(c.xa) + int'($urandom_range(80)) - 40);
            end
            2: begin
                c.func = FN_VLINE;
                if ($urandom_range(3) != 0)
                    c.yb = 16'(int'(c.ya) + int'($urandom_range(80)) - 40);
            end
            3: begin
                c.func = FN_RECT;
                c.xb = 16'(int'(c.xa) + int'($urandom_range(14)) - 7);
                c.yb = 16'(int'(c.ya) + int'($urandom_range(14)) - 7);
            end
            4: begin
                c.func = FN_CIRCLE;
                c.radius = ($urandom_range(19) == 0) ? 8'($urandom_range(40))
                                                     : 8'($urandom_range(8));
            end
            default: begin
                c.func = FN_DISC;
                c.radius = ($urandom_range(29) == 0) ? 8'($urandom_range(12))
                                                     : 8'($urandom_range(3));
            end
        endcase
        return c;
    endfunction

    function automatic t_cmd tick_item();
        t_cmd c;
        c = random_primitive();
        c.func = FN_TICK;
        return c;
    endfunction

    // offer one transaction, with random idle cycles ahead of it
    task automatic send_item(t_cmd c);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.func;
        s_axis_tdata <= {c.color, c.radius, c.yb, c.xb, c.ya, c.xa};
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.note_input(c)) counted_items++;
    endtask

    // load a primitive and tick it to the end, optionally mixing in ignored items
    task automatic run_primitive(t_cmd c, bit noisy);
        t_cmd n;
        send_item(c);
        while (sb.busy()) begin
            if (noisy && $urandom_range(15) == 0) begin
                n = random_primitive();
                if ($urandom_range(1) != 0) n.func = FN_UNUSED;
                send_item(n);
            end else begin
                send_item(tick_item());
            end
        end
    endtask

    task automatic random_phase(int tx_pct, int rx_pct, int quota);
        int   start_cnt;
        t_cmd n;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        start_cnt = counted_items;
        while (counted_items - start_cnt < quota) begin
            // occasional idle tick or unused selector
            if ($urandom_range(9) == 0) begin
                n = tick_item();
                if ($urandom_range(1) != 0) n.func = FN_UNUSED;
                send_item(n);
            end
            run_primitive(random_primitive(), 1'b1);
        end
    endtask

    // stimulus
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick and unused selector
        send_item(make_cmd(FN_TICK, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(FN_UNUSED, -1, -1, -1, -1, 255, 255));
        // single pixels: corners, off screen, field extremes
        run_primitive(make_cmd(FN_PIXEL, 0, 0, 0, 0, 0, 0), 1'b0);
        run_primitive(make_cmd(FN_PIXEL, 319, 199, 0, 0, 255, 255), 1'b0);
        run_primitive(make_cmd(FN_PIXEL, -1, 200, 0, 0, 3, 17), 1'b0);
        run_primitive(make_cmd(FN_PIXEL, -32768, 32767, 0, 0, 0, 1), 1'b0);
        run_primitive(make_cmd(FN_PIXEL, 32767, -32768, 0, 0, 0, 2), 1'b0);
        // lines: swapped and clamped, rows and columns off screen, empty after clamp
        run_primitive(make_cmd(FN_HLINE, 5, 0, -50, 0, 0, 33), 1'b0);
        run_primitive(make_cmd(FN_HLINE, 330, 199, 310, 0, 0, 32), 1'b0);
        run_primitive(make_cmd(FN_HLINE, 0, -1, 100, 0, 0, 34), 1'b0);
        run_primitive(make_cmd(FN_HLINE, 0, 200, 100, 0, 0, 35), 1'b0);
        run_primitive(make_cmd(FN_HLINE, -30, 50, -5, 0, 0, 36), 1'b0);
        run_primitive(make_cmd(FN_VLINE, 319, 250, 0, 190, 0, 37), 1'b0);
        run_primitive(make_cmd(FN_VLINE, 0, 3, 0, -10, 0, 39), 1'b0);
        run_primitive(make_cmd(FN_VLINE, 320, 0, 0, 100, 0, 38), 1'b0);
        // rectangles: swapped corners, clamped at field extremes, empty
        run_primitive(make_cmd(FN_RECT, 10, 20, 3, 5, 0, 40), 1'b0);
        run_primitive(make_cmd(FN_RECT, -32768, -32768, 2, 1, 0, 41), 1'b0);
        run_primitive(make_cmd(FN_RECT, 32767, 32767, 317, 197, 0, 43), 1'b0);
        run_primitive(make_cmd(FN_RECT, -9, -9, -1, -1, 0, 42), 1'b0);
        // circles: zero radius, at the edge, wide, far off screen
        run_primitive(make_cmd(FN_CIRCLE, 5, 5, 0, 0, 0, 50), 1'b0);
        run_primitive(make_cmd(FN_CIRCLE, 1, 1, 0, 0, 1, 51), 1'b0);
        run_primitive(make_cmd(FN_CIRCLE, 160, 100, 0, 0, 60, 52), 1'b0);
        run_primitive(make_cmd(FN_CIRCLE, 32767, -32768, 0, 0, 5, 53), 1'b0);
        // discs: zero radius, at the edge, wide
        run_primitive(make_cmd(FN_DISC, 319, 199, 0, 0, 0, 60), 1'b0);
        run_primitive(make_cmd(FN_DISC, -2, 198, 0, 0, 3, 61), 1'b0);
        run_primitive(make_cmd(FN_DISC, 160, 100, 0, 0, 8, 62), 1'b0);
        // commands while busy are ignored
        send_item(make_cmd(FN_RECT, 100, 100, 104, 102, 0, 70));
        send_item(tick_item());
        send_item(make_cmd(FN_CIRCLE, 10, 10, 0, 0, 4, 71));
        send_item(make_cmd(FN_UNUSED, 0, 0, 0, 0, 0, 72));
        while (sb.busy()) send_item(tick_item());

        // long receiver hold-off while ticks keep coming, so the input backs up
        send_item(make_cmd(FN_RECT, 10, 10, 19, 19, 0, 90));
        fork
            begin
                rx_hold <= 1'b1;
                repeat (200) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        while (sb.busy()) send_item(tick_item());

        // random streams under each idle and stall mix
        random_phase(0, 0, 110);
        random_phase(53, 0, 110);
        random_phase(0, 53, 110);
        random_phase(28, 28, 110);

        // drain
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        sb.check_drained();
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
